FILE: rtl/core/krlt_pkg.sv
// Package: shared types, codes and defaults for the keyed record list table.
package krlt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BYTES    = 20;
  localparam int POS_W        = 4;
  localparam int CNT_OUT_W    = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_RSVD   = 2'd3
  } req_e_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    POS_ZERO  = 2'd0,
    POS_COUNT = 2'd1,
    POS_PTR   = 2'd2
  } pos_sel_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_SEARCH = 3'd2,
    S_SHIFT  = 3'd3,
    S_DONE   = 3'd4
  } state_t;

  typedef struct packed {
    logic [63:0] key0;
    logic [63:0] key1;
    logic [31:0] key2;
    logic [31:0] id;
    logic [31:0] grade;
  } record_t;

  typedef struct packed {
    logic      req_load;
    logic      ptr_clr;
    logic      ptr_inc;
    logic      wr_insert;
    logic      wr_shift;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      res_we;
    status_e_t res_status;
    logic      res_found;
    pos_sel_t  res_pos_sel;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    req_e_t req;
    logic   full;
    logic   empty;
    logic   match;
    logic   last;
    logic   shift_more;
    logic   out_busy;
  } sts_t;

endpackage

FILE: rtl/core/keyed_record_list_table_top.sv
// Top level: keyed record list table, controller plus datapath.
//
// A fixed-capacity list of CAPACITY records (20-byte key, id, grade) held in
// insertion order. Each input transaction carries one request: insert at end,
// search by key, or delete by key; each yields exactly one result transaction
// with status, found flag, position and the record count after the request.
// Channels use valid/stall; a transaction moves when valid is high and stall
// is low. One request is in work at a time: in_stall stays high from accept
// until the result is loaded into the output register.
// Insert and reserved requests need no walk of the list. A search walks the
// record memory, which has one read and one write port, one slot per cycle
// from slot 0 until a hit or the last record; a delete walks it the same way
// and, on a hit, moves each later record down one slot, one record per cycle.
// The result waits in the output register while out_stall is high; the next
// request is accepted meanwhile and holds in its final step until the
// register frees. Reset empties the list; no clearing pass is needed.
module keyed_record_list_table_top
  import krlt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [63:0]        in_name_word0,
  input  logic [63:0]        in_name_word1,
  input  logic [31:0]        in_name_word2,
  input  logic signed [31:0] in_student_id,
  input  logic [31:0]        in_grade_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [3:0]         out_position,
  output logic [4:0]         out_entry_count
);

  cmd_t cmd;
  sts_t sts;

  krlt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  krlt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_name_word0   (in_name_word0),
    .in_name_word1   (in_name_word1),
    .in_name_word2   (in_name_word2),
    .in_student_id   (in_student_id),
    .in_grade_bits   (in_grade_bits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_insert |-> !sts.full)
    else $error("insert write issued on a full list");

  a_no_dec_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !sts.empty)
    else $error("count decrement on an empty list");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the request finished");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result load did not raise out_valid");

endmodule

FILE: rtl/core/krlt_ctrl.sv
// Controller: request sequencing state machine for the keyed record list table.
module krlt_ctrl
  import krlt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req)
          REQ_SEARCH: state_nxt = sts.empty ? S_DONE : S_SEARCH;
          REQ_DELETE: state_nxt = sts.empty ? S_DONE : S_SEARCH;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_SEARCH: begin
        if (sts.match) begin
          state_nxt = (sts.req == REQ_DELETE) ? S_SHIFT : S_DONE;
        end else if (sts.last) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!sts.shift_more) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.res_status  = ST_OK;
    cmd.res_pos_sel = POS_ZERO;
    in_stall        = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          cmd.ptr_clr  = 1'b1;
        end
      end
      S_DECODE: begin
        case (sts.req)
          REQ_INSERT: begin
            cmd.res_we = 1'b1;
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_insert   = 1'b1;
              cmd.cnt_inc     = 1'b1;
              cmd.res_pos_sel = POS_COUNT;
            end
          end
          REQ_SEARCH: begin
            if (sts.empty) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_NOTFOUND;
            end
          end
          REQ_DELETE: begin
            if (sts.empty) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_EMPTY;
            end
          end
          default: begin
            cmd.res_we = 1'b1;
          end
        endcase
      end
      S_SEARCH: begin
        if (sts.match) begin
          cmd.res_we      = 1'b1;
          cmd.res_found   = 1'b1;
          cmd.res_pos_sel = POS_PTR;
          cmd.ptr_inc     = (sts.req == REQ_DELETE);
        end else if (sts.last) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_NOTFOUND;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_more) begin
          cmd.wr_shift = 1'b1;
          cmd.ptr_inc  = 1'b1;
        end else begin
          cmd.cnt_dec = 1'b1;
        end
      end
      S_DONE: begin
        cmd.out_load = !sts.out_busy;
      end
      default: begin
        cmd.ptr_clr = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/core/krlt_dpath.sv
// Datapath: record memory, pointer, count, result and output registers.
module krlt_dpath
  import krlt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_req_type,
  input  logic [63:0]        in_name_word0,
  input  logic [63:0]        in_name_word1,
  input  logic [31:0]        in_name_word2,
  input  logic signed [31:0] in_student_id,
  input  logic [31:0]        in_grade_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [3:0]         out_position,
  output logic [4:0]         out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  record_t mem [CAPACITY];

  req_e_t    req_r;
  record_t   req_rec_r;
  record_t   rd_data_r;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] shift_dst;
  logic          wr_en;
  record_t       wr_data;
  logic [CW:0]   ptr_plus1;
  status_e_t     res_status_r;
  logic          res_found_r;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic          out_found_r;
  logic [POS_W-1:0]     out_position_r;
  logic [CNT_OUT_W-1:0] out_entry_count_r;

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign rd_addr   = (ptr_nxt < CAP_C) ? ptr_nxt[IW-1:0] : '0;
  assign shift_dst = ptr_r - 1'b1;
  assign wr_en     = cmd.wr_insert | cmd.wr_shift;
  assign wr_addr   = cmd.wr_shift ? shift_dst[IW-1:0] : count_r[IW-1:0];
  assign wr_data   = cmd.wr_shift ? rd_data_r : req_rec_r;
  assign ptr_plus1 = {1'b0, ptr_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r           <= req_e_t'(in_req_type);
      req_rec_r.key0  <= in_name_word0;
      req_rec_r.key1  <= in_name_word1;
      req_rec_r.key2  <= in_name_word2;
      req_rec_r.id    <= in_student_id;
      req_rec_r.grade <= in_grade_bits;
    end
  end

  always_comb begin
    case (cmd.res_pos_sel)
      POS_COUNT: res_pos_nxt = POS_W'(count_r);
      POS_PTR:   res_pos_nxt = POS_W'(ptr_r);
      default:   res_pos_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_status_r <= cmd.res_status;
      res_found_r  <= cmd.res_found;
      res_pos_r    <= res_pos_nxt;
    end
    if (cmd.out_load) begin
      out_status_r      <= res_status_r;
      out_found_r       <= res_found_r;
      out_position_r    <= res_pos_r;
      out_entry_count_r <= CNT_OUT_W'(count_r);
    end
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    sts.req        = req_r;
    sts.full       = (count_r == CAP_C);
    sts.empty      = (count_r == '0);
    sts.match      = (rd_data_r.key0 == req_rec_r.key0) &&
                     (rd_data_r.key1 == req_rec_r.key1) &&
                     (rd_data_r.key2 == req_rec_r.key2);
    sts.last       = (ptr_plus1 >= {1'b0, count_r});
    sts.shift_more = (ptr_r < count_r);
    sts.out_busy   = out_valid_r & out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_position    = out_position_r;
  assign out_entry_count = out_entry_count_r;

endmodule

FILE: bench/keyed_record_list_table_top_test.sv
// Testbench: keyed record list table, directed table then random requests vs. a list predictor.
`timescale 1ns / 1ps

module keyed_record_list_table_top_test;
  import krlt_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 900;
  localparam int POOL_SIZE    = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    req_e_t             req;
    logic [63:0]        k0;
    logic [63:0]        k1;
    logic [31:0]        k2;
    logic signed [31:0] id;
    logic [31:0]        grade;
  } list_req_t;

  typedef struct packed {
    status_e_t   status;
    logic        found;
    logic [3:0]  pos;
    logic [4:0]  cnt;
  } list_result_t;

  typedef struct {
    list_req_t    rq;
    int           reps;
    bit           typed;
    list_result_t res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_req_type = '0;
  logic [63:0]        in_name_word0 = '0;
  logic [63:0]        in_name_word1 = '0;
  logic [31:0]        in_name_word2 = '0;
  logic signed [31:0] in_student_id = '0;
  logic [31:0]        in_grade_bits = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic               out_found;
  logic [3:0]         out_position;
  logic [4:0]         out_entry_count;

  keyed_record_list_table_top #(.CAPACITY(CAP)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_name_word0   (in_name_word0),
    .in_name_word1   (in_name_word1),
    .in_name_word2   (in_name_word2),
    .in_student_id   (in_student_id),
    .in_grade_bits   (in_grade_bits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the list
  logic [63:0]        held_k0 [CAP];
  logic [63:0]        held_k1 [CAP];
  logic [31:0]        held_k2 [CAP];
  logic signed [31:0] held_id [CAP];
  logic [31:0]        held_grade [CAP];
  int                 held_count = 0;

  list_result_t pending_results [$];
  stim_row_t    directed_rows [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           traffic_phase = 0;
  logic         hold_trigger = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;

  logic [63:0] pool_k0 [POOL_SIZE];
  logic [63:0] pool_k1 [POOL_SIZE];
  logic [31:0] pool_k2 [POOL_SIZE];

  function automatic list_result_t list_apply(list_req_t r);
    list_result_t res;
    int hit;
    res.status = ST_OK;
    res.found  = 1'b0;
    res.pos    = '0;
    hit = -1;
    for (int p = 0; p < held_count; p++) begin
      if (hit < 0 && held_k0[p] == r.k0 && held_k1[p] == r.k1 && held_k2[p] == r.k2)
        hit = p;
    end
    case (r.req)
      REQ_INSERT: begin
        if (held_count >= CAP) begin
          res.status = ST_FULL;
        end else begin
          res.pos                = 4'(held_count);
          held_k0[held_count]    = r.k0;
          held_k1[held_count]    = r.k1;
          held_k2[held_count]    = r.k2;
          held_id[held_count]    = r.id;
          held_grade[held_count] = r.grade;
          held_count++;
        end
      end
      REQ_SEARCH: begin
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.found = 1'b1;
          res.pos   = 4'(hit);
        end
      end
      REQ_DELETE: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.found = 1'b1;
          res.pos   = 4'(hit);
          for (int j = hit + 1; j < held_count; j++) begin
            held_k0[j-1]    = held_k0[j];
            held_k1[j-1]    = held_k1[j];
            held_k2[j-1]    = held_k2[j];
            held_id[j-1]    = held_id[j];
            held_grade[j-1] = held_grade[j];
          end
          held_count--;
        end
      end
      default: ;
    endcase
    res.cnt = 5'(held_count);
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_row(req_e_t req, logic [63:0] k0, logic [63:0] k1,
                                  logic [31:0] k2, logic [31:0] id, logic [31:0] grade,
                                  int reps, bit typed, status_e_t st, bit fnd,
                                  int pos, int cnt);
    stim_row_t row;
    row.rq.req       = req;
    row.rq.k0        = k0;
    row.rq.k1        = k1;
    row.rq.k2        = k2;
    row.rq.id        = id;
    row.rq.grade     = grade;
    row.reps         = reps;
    row.typed        = typed;
    row.res.status   = st;
    row.res.found    = fnd;
    row.res.pos      = 4'(pos);
    row.res.cnt      = 5'(cnt);
    directed_rows.push_back(row);
  endfunction

  task automatic send_request(list_req_t rq, bit use_typed, list_result_t typed_res);
    int gap_pct;
    list_result_t predicted;
    gap_pct = (traffic_phase == 0) ? 15 : (traffic_phase == 1) ? 50 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rq.req;
    in_name_word0 <= rq.k0;
    in_name_word1 <= rq.k1;
    in_name_word2 <= rq.k2;
    in_student_id <= rq.id;
    in_grade_bits <= rq.grade;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = list_apply(rq);
    pending_results.push_back(use_typed ? typed_res : predicted);
  endtask

  task automatic check_field(string fname, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: random stall, plus one long hold-off
  always @(posedge clk) begin
    int recv_pct;
    recv_pct = (traffic_phase == 0) ? 50 : (traffic_phase == 1) ? 15 : 0;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_trigger && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: extra transaction: expected none, actual %0d %0d %0d %0d",
                 $time, out_status, out_found, out_position, out_entry_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("found", want.found, out_found);
        check_field("position", want.pos, out_position);
        check_field("entry_count", want.cnt, out_entry_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyed_record_list_table_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    list_req_t    rq;
    list_result_t none;
    int           pick;
    int           slot;
    logic [63:0]  ones64;
    logic [63:0]  sparse0;

    none    = '0;
    ones64  = '1;
    sparse0 = 64'h0000_0041_0000_0042;

    add_row(REQ_SEARCH, 0, 0, 0, 0, 0, 1, 1, ST_NOTFOUND, 0, 0, 0);
    add_row(REQ_DELETE, 0, 0, 0, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0);
    add_row(REQ_RSVD, 0, 0, 0, 0, 0, 1, 1, ST_OK, 0, 0, 0);
    add_row(REQ_INSERT, 0, 0, 0, 0, 0, 1, 1, ST_OK, 0, 0, 1);
    add_row(REQ_INSERT, ones64, ones64, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
            1, 1, ST_OK, 0, 1, 2);
    add_row(REQ_INSERT, sparse0, 64'h43, 0, 32'h7FFF_FFFF, 0, 1, 1, ST_OK, 0, 2, 3);
    add_row(REQ_SEARCH, ones64, ones64, 32'hFFFF_FFFF, 0, 0, 1, 1, ST_OK, 1, 1, 3);
    add_row(REQ_SEARCH, ones64, ones64, 0, 0, 0, 1, 1, ST_NOTFOUND, 0, 0, 3);
    add_row(REQ_RSVD, ones64, ones64, 32'hFFFF_FFFF, 0, 0, 1, 1, ST_OK, 0, 0, 3);
    add_row(REQ_DELETE, 0, 0, 0, 0, 0, 1, 1, ST_OK, 1, 0, 2);
    add_row(REQ_SEARCH, ones64, ones64, 32'hFFFF_FFFF, 0, 0, 1, 0, ST_OK, 0, 0, 0);
    add_row(REQ_DELETE, 1, 0, 0, 0, 0, 1, 1, ST_NOTFOUND, 0, 0, 2);
    add_row(REQ_INSERT, 64'h1000, 0, 0, 32'h55, 32'hAA, 14, 0, ST_OK, 0, 0, 0);
    add_row(REQ_INSERT, 64'h2000, 0, 0, 0, 0, 1, 1, ST_FULL, 0, 0, 16);
    add_row(REQ_SEARCH, 64'h100D, 0, 0, 0, 0, 1, 0, ST_OK, 0, 0, 0);
    add_row(REQ_DELETE, 64'h100D, 0, 0, 0, 0, 1, 0, ST_OK, 0, 0, 0);
    add_row(REQ_DELETE, ones64, ones64, 32'hFFFF_FFFF, 0, 0, 1, 0, ST_OK, 0, 0, 0);
    add_row(REQ_INSERT, sparse0, 64'h43, 0, 32'h1234, 32'h5678, 1, 0, ST_OK, 0, 0, 0);
    add_row(REQ_SEARCH, sparse0, 64'h43, 0, 0, 0, 1, 0, ST_OK, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].reps; i++) begin
        rq = directed_rows[r].rq;
        if (directed_rows[r].reps > 1) rq.k0 = rq.k0 + 64'(i);
        send_request(rq, directed_rows[r].typed, directed_rows[r].res);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      traffic_phase = n / 300;
      if (n == 150) hold_trigger <= 1'b1;
      if (n % 100 == 0) begin
        for (int p = 0; p < POOL_SIZE; p++) begin
          pool_k0[p] = rand64();
          pool_k1[p] = ($urandom_range(1) == 0) ? 64'h0 : rand64();
          pool_k2[p] = ($urandom_range(1) == 0) ? 32'h0 : $urandom;
        end
        // near misses: differ from slot 0 in one word only
        pool_k0[1] = pool_k0[0];
        pool_k1[1] = pool_k1[0];
        pool_k0[2] = pool_k0[0];
        pool_k2[2] = pool_k2[0];
        pool_k1[3] = pool_k1[0];
        pool_k2[3] = pool_k2[0];
      end
      pick = $urandom_range(99);
      if ((n / 100) % 2 == 0)
        rq.req = (pick < 50) ? REQ_INSERT : (pick < 75) ? REQ_SEARCH :
                 (pick < 95) ? REQ_DELETE : REQ_RSVD;
      else
        rq.req = (pick < 20) ? REQ_INSERT : (pick < 50) ? REQ_SEARCH :
                 (pick < 95) ? REQ_DELETE : REQ_RSVD;
      if ($urandom_range(99) < 85) begin
        slot  = $urandom_range(POOL_SIZE - 1);
        rq.k0 = pool_k0[slot];
        rq.k1 = pool_k1[slot];
        rq.k2 = pool_k2[slot];
      end else begin
        rq.k0 = rand64();
        rq.k1 = rand64();
        rq.k2 = $urandom;
      end
      rq.id    = $urandom;
      rq.grade = $urandom;
      send_request(rq, 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("keyed_record_list_table_top_test OK");
    else
      $display("keyed_record_list_table_top_test NOT OK");
    $finish;
  end

endmodule
